/* hdl/hrbi_pkg.sv */
package hrbi_pkg;

  // Field widths
  localparam int TS_W        = 32;
  localparam int WIN_W       = 16;
  localparam int LIMIT_W     = 4;
  localparam int RATE_W      = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Arithmetic constants
  localparam int MS_PER_MINUTE = 60000;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Register reset values
  localparam logic [WIN_W-1:0]   INTERVAL_LOW_RST  = 16'd600;
  localparam logic [WIN_W-1:0]   INTERVAL_HIGH_RST = 16'd1200;
  localparam logic [WIN_W-1:0]   JITTER_LIMIT_RST  = 16'd100;
  localparam logic [TS_W-1:0]    STALE_TIMEOUT_RST = 32'd5000;
  localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST   = 4'd4;

  // Default sizes of the beat store and the trim
  localparam int DEF_BEATS_KEPT    = 10;
  localparam int DEF_TRIMMED_COUNT = 2;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INTERVAL_LOW  = 3'd0,
    REG_INTERVAL_HIGH = 3'd1,
    REG_JITTER_LIMIT  = 3'd2,
    REG_STALE_TIMEOUT = 3'd3,
    REG_FAULT_LIMIT   = 3'd4
  } reg_index_t;

  // Request operations
  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic measure;
    logic read_apply;
    logic fault;
    logic beat_start;
    logic beat_store;
    logic scan_init;
    logic scan_issue;
    logic scan_close;
    logic mean_start;
    logic mean_load;
    logic mean_zero;
    logic result_load;
  } hrbi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_read;
    logic beat_ok;
    logic div_done;
    logic count_full;
    logic span_ok;
    logic idx_last;
    logic pass_last;
  } hrbi_status_t;

endpackage

/* hdl/hrbi_channels.sv */
// Request channel: one pulse edge or read with its timestamp
interface hrbi_request_if;
  import hrbi_pkg::*;

  logic            valid;
  logic            ready;
  logic            operation;
  logic [TS_W-1:0] timestamp_ms;

  modport source (output valid, output operation, output timestamp_ms, input ready);
  modport sink   (input valid, input operation, input timestamp_ms, output ready);
endinterface

// Result channel: heart rate after each request
interface hrbi_result_if;
  import hrbi_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] heart_rate;
  logic              new_average;

  modport source (output valid, output heart_rate, output new_average, input ready);
  modport sink   (input valid, input heart_rate, input new_average, output ready);
endinterface

/* hdl/hrbi_divider.sv */
module hrbi_divider #(
  parameter int DIVIDEND_W = 19,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);
  localparam int COUNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [COUNT_W-1:0]   count;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] trial;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, divisor};
  end

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= COUNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - COUNT_W'(1);
        if (count == COUNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[DIVISOR_W]) begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

/* hdl/hrbi_datapath.sv */
module hrbi_datapath #(
  parameter int BEATS_KEPT    = hrbi_pkg::DEF_BEATS_KEPT,
  parameter int TRIMMED_COUNT = hrbi_pkg::DEF_TRIMMED_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hrbi_pkg::hrbi_cmd_t              cmd,
  output hrbi_pkg::hrbi_status_t           status,
  input  logic                             operation,
  input  logic [hrbi_pkg::TS_W-1:0]        timestamp_ms,
  input  logic                             cfg_write,
  input  logic [hrbi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hrbi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [hrbi_pkg::RATE_W-1:0]      heart_rate,
  output logic                             new_average
);
  import hrbi_pkg::*;

  localparam int TRIM_EACH = TRIMMED_COUNT / 2;
  localparam bit SPAN_OK   = BEATS_KEPT > 2 * TRIM_EACH;
  localparam int KEPT_SPAN = SPAN_OK ? BEATS_KEPT - 2 * TRIM_EACH : 1;
  localparam int PASSES    = (TRIM_EACH > 0) ? TRIM_EACH : 1;
  localparam int PASS_W    = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CNT_W     = $clog2(BEATS_KEPT);
  localparam int SUM_W     = RATE_W + $clog2(BEATS_KEPT);

  // Reciprocal of the kept span, exact for every sum below 2^SUM_W
  localparam int MEAN_SHIFT = SUM_W + $clog2(KEPT_SPAN);
  localparam int PROD_W     = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] MEAN_RECIP =
    (SUM_W + 1)'(((longint'(1) << MEAN_SHIFT) + longint'(KEPT_SPAN) - 1) /
                 longint'(KEPT_SPAN));

  // Configuration registers
  logic [WIN_W-1:0]   interval_low;
  logic [WIN_W-1:0]   interval_high;
  logic [WIN_W-1:0]   jitter_limit;
  logic [TS_W-1:0]    stale_timeout;
  logic [LIMIT_W-1:0] fault_limit;

  // Beat tracking state
  op_t                op_reg;
  logic [TS_W-1:0]    ts_reg;
  logic [TS_W-1:0]    iv;
  logic [TS_W-1:0]    last_edge_time;
  logic [WIN_W-1:0]   reference_interval;
  logic [LIMIT_W-1:0] fault_count;
  logic [CNT_W-1:0]   beat_count;
  logic [RATE_W-1:0]  rate_register;
  logic               fresh;

  // Beat store and scan state
  logic [RATE_W-1:0]     beat_mem [BEATS_KEPT];
  logic [CNT_W-1:0]      scan_idx;
  logic [PASS_W-1:0]     pass;
  logic                  rd_valid;
  logic [CNT_W-1:0]      rd_idx;
  logic [RATE_W-1:0]     rd_data;
  logic [BEATS_KEPT-1:0] lo_mark;
  logic [BEATS_KEPT-1:0] hi_mark;
  logic                  lo_found;
  logic                  hi_found;
  logic [RATE_W-1:0]     lo_best;
  logic [RATE_W-1:0]     hi_best;
  logic [CNT_W-1:0]      lo_idx;
  logic [CNT_W-1:0]      hi_idx;
  logic [SUM_W-1:0]      total;
  logic [SUM_W-1:0]      trim_sum;

  // Trimmed mean by reciprocal multiplication
  logic [SUM_W-1:0]  mean_base;
  logic [PROD_W-1:0] mean_prod;
  logic [RATE_W-1:0] mean_value;

  // Divider operands
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [WIN_W-1:0] div_divisor;
  logic [SUM_W-1:0] div_quotient;
  logic             div_done;

  // Edge evaluation
  logic               in_window;
  logic [WIN_W-1:0]   iv16;
  logic [WIN_W-1:0]   ref_eff;
  logic [WIN_W-1:0]   diff;
  logic               jitter_ok;
  logic               stale;
  logic [LIMIT_W-1:0] fault_inc;
  logic               fault_hit;
  logic [RATE_W-1:0]  beat_sat;

  always_comb begin
    iv16      = iv[WIN_W-1:0];
    in_window = (iv > {16'd0, interval_low}) && (iv < {16'd0, interval_high});
    ref_eff   = (reference_interval == '0) ? iv16 : reference_interval;
    diff      = (ref_eff > iv16) ? ref_eff - iv16 : iv16 - ref_eff;
    jitter_ok = diff < jitter_limit;
    stale     = iv > stale_timeout;
    fault_inc = fault_count + LIMIT_W'(1);
    fault_hit = fault_inc >= fault_limit;
    beat_sat  = (|div_quotient[SUM_W-1:RATE_W]) ? RATE_MAX : div_quotient[RATE_W-1:0];
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_low  <= INTERVAL_LOW_RST;
      interval_high <= INTERVAL_HIGH_RST;
      jitter_limit  <= JITTER_LIMIT_RST;
      stale_timeout <= STALE_TIMEOUT_RST;
      fault_limit   <= FAULT_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTERVAL_LOW:  interval_low  <= cfg_data[WIN_W-1:0];
        REG_INTERVAL_HIGH: interval_high <= cfg_data[WIN_W-1:0];
        REG_JITTER_LIMIT:  jitter_limit  <= cfg_data[WIN_W-1:0];
        REG_STALE_TIMEOUT: stale_timeout <= cfg_data[TS_W-1:0];
        REG_FAULT_LIMIT:   fault_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request and measure the interval since the last edge
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg <= op_t'(operation);
      ts_reg <= timestamp_ms;
    end
    if (cmd.measure) begin
      iv <= ts_reg - last_edge_time;
    end
  end

  // Tracking state: reference, faults, beat count and rate
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time     <= '0;
      reference_interval <= '0;
      fault_count        <= '0;
      beat_count         <= '0;
      rate_register      <= '0;
      fresh              <= 1'b0;
    end else begin
      if (cmd.measure) begin
        fresh <= 1'b0;
        if (op_reg == OP_EDGE) begin
          last_edge_time <= ts_reg;
        end
      end
      if (cmd.read_apply && stale) begin
        rate_register <= '0;
      end
      if (cmd.fault) begin
        if (fault_hit) begin
          reference_interval <= '0;
          fault_count        <= '0;
        end else begin
          fault_count <= fault_inc;
          if (in_window) begin
            reference_interval <= ref_eff;
          end
        end
      end
      if (cmd.beat_start) begin
        reference_interval <= iv16;
        fault_count        <= '0;
      end
      if (cmd.beat_store) begin
        beat_count <= status.count_full ? '0 : beat_count + CNT_W'(1);
      end
      if (cmd.mean_load) begin
        rate_register <= mean_value;
        fresh         <= 1'b1;
      end
      if (cmd.mean_zero) begin
        rate_register <= '0;
        fresh         <= 1'b1;
      end
    end
  end

  // Beat store: write the new beat, read one entry per scan step
  always_ff @(posedge clk) begin
    if (cmd.beat_store) begin
      beat_mem[beat_count] <= beat_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_data <= beat_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
    end
  end

  // Scan: total on the first pass, lowest and highest unmarked each pass
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx <= '0;
      pass     <= '0;
      lo_mark  <= '0;
      hi_mark  <= '0;
      lo_found <= 1'b0;
      hi_found <= 1'b0;
      total    <= '0;
      trim_sum <= '0;
    end else begin
      if (cmd.scan_issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
        rd_idx   <= scan_idx;
      end
      if (rd_valid) begin
        if (pass == '0) begin
          total <= total + SUM_W'(rd_data);
        end
        if (!lo_mark[rd_idx] && (!lo_found || rd_data < lo_best)) begin
          lo_best  <= rd_data;
          lo_idx   <= rd_idx;
          lo_found <= 1'b1;
        end
        if (!hi_mark[rd_idx] && (!hi_found || rd_data >= hi_best)) begin
          hi_best  <= rd_data;
          hi_idx   <= rd_idx;
          hi_found <= 1'b1;
        end
      end
      if (cmd.scan_close) begin
        scan_idx <= '0;
        pass     <= pass + PASS_W'(1);
        lo_found <= 1'b0;
        hi_found <= 1'b0;
        if (TRIM_EACH > 0) begin
          lo_mark[lo_idx] <= 1'b1;
          hi_mark[hi_idx] <= 1'b1;
          trim_sum        <= trim_sum + SUM_W'(lo_best) + SUM_W'(hi_best);
        end
      end
    end
  end

  // Mean of the kept beats: multiply by the reciprocal and keep the high bits
  always_comb begin
    mean_base = total - trim_sum;
    mean_prod = PROD_W'(mean_base) * PROD_W'(MEAN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_start) begin
      mean_value <= mean_prod[MEAN_SHIFT +: RATE_W];
    end
  end

  // Serial divider for the beat value
  always_comb begin
    div_start    = cmd.beat_start;
    div_dividend = SUM_W'(MS_PER_MINUTE);
    div_divisor  = iv16;
  end

  hrbi_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (WIN_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      heart_rate  <= rate_register;
      new_average <= fresh;
    end
  end

  // Status
  always_comb begin
    status.is_read    = op_reg == OP_READ;
    status.beat_ok    = in_window && jitter_ok;
    status.div_done   = div_done;
    status.count_full = beat_count == CNT_W'(BEATS_KEPT - 1);
    status.span_ok    = SPAN_OK;
    status.idx_last   = scan_idx == CNT_W'(BEATS_KEPT - 1);
    status.pass_last  = pass == PASS_W'(PASSES - 1);
  end

endmodule

/* hdl/hrbi_controller.sv */
module hrbi_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   res_valid,
  input  logic                   res_ready,
  input  hrbi_pkg::hrbi_status_t status,
  output hrbi_pkg::hrbi_cmd_t    cmd
);
  import hrbi_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_MEASURE   = 10'b0000000010,
    S_CHECK     = 10'b0000000100,
    S_BEAT      = 10'b0000001000,
    S_SCAN      = 10'b0000010000,
    S_TAIL      = 10'b0000100000,
    S_CLOSE     = 10'b0001000000,
    S_MEAN      = 10'b0010000000,
    S_MEAN_WAIT = 10'b0100000000,
    S_FINISH    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one request through the datapath
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_MEASURE;
        end
      end
      S_MEASURE: begin
        cmd.measure = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        if (status.is_read) begin
          cmd.read_apply = 1'b1;
          state_next     = S_FINISH;
        end else if (status.beat_ok) begin
          cmd.beat_start = 1'b1;
          state_next     = S_BEAT;
        end else begin
          cmd.fault  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_BEAT: begin
        if (status.div_done) begin
          cmd.beat_store = 1'b1;
          if (!status.count_full) begin
            state_next = S_FINISH;
          end else if (status.span_ok) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            cmd.mean_zero = 1'b1;
            state_next    = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.idx_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.scan_close = 1'b1;
        state_next     = status.pass_last ? S_MEAN : S_SCAN;
      end
      S_MEAN: begin
        cmd.mean_start = 1'b1;
        state_next     = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        cmd.mean_load = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (!res_valid || res_ready) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.result_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

/* hdl/heart_rate_from_beat_intervals.sv */
// Heart rate from beat intervals. Each request is a pulse edge or a read with a wrapping
// millisecond timestamp, and each gives one result: the current rate in beats per minute
// and a flag that marks an edge which completed a new trimmed average, or which set a zero
// rate because the trim leaves no beats to keep. A read, or an edge whose interval is
// rejected, passes through the measure, check and finish states to the result register.
// An accepted beat runs the serial divider for 60000/interval, one quotient bit per cycle,
// on SUM_W = 15 + clog2(BEATS_KEPT) bits (19 at the default sizes). The beat that fills the
// store adds max(TRIMMED_COUNT/2, 1) walks over the store, one entry read per cycle from its
// single port, and then the mean, taken by a multiplication with the reciprocal of the kept
// span. A new request is taken as soon as the previous one has moved into the result
// register, even while that result still waits. Entries of the beat store are read only
// after all of them have been written since reset, so the store needs no clearing pass.
// Configuration must be written only while the block idles; the block does not enforce it.
module heart_rate_from_beat_intervals #(
  parameter int BEATS_KEPT    = hrbi_pkg::DEF_BEATS_KEPT,
  parameter int TRIMMED_COUNT = hrbi_pkg::DEF_TRIMMED_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  hrbi_request_if.sink                     request,
  hrbi_result_if.source                    result,
  input  logic                             cfg_write,
  input  logic [hrbi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hrbi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hrbi_pkg::*;

  hrbi_cmd_t    cmd;
  hrbi_status_t status;
  logic         req_ready;
  logic         res_valid;

  assign request.ready = req_ready;
  assign result.valid  = res_valid;

  hrbi_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hrbi_datapath #(
    .BEATS_KEPT    (BEATS_KEPT),
    .TRIMMED_COUNT (TRIMMED_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (request.operation),
    .timestamp_ms (request.timestamp_ms),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .heart_rate   (result.heart_rate),
    .new_average  (result.new_average)
  );

endmodule
